// File: rtl/gpm_pkg.sv
// Shared constants and field widths for the GPIO pin mode controller.
package gpm_pkg;

	localparam int NUM_PORTS     = 4;
	localparam int PINS_PER_PORT = 16;
	localparam int DEPTH         = NUM_PORTS * PINS_PER_PORT;
	localparam int ADDR_W        = $clog2(DEPTH);

	localparam int CMD_W   = 4;
	localparam int PORT_W  = 2;
	localparam int PIN_W   = 4;
	localparam int MODE_W  = 4;
	localparam int LEVEL_W = 2;
	localparam int NIB_W   = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [CMD_W-1:0] CMD_SET_MODE   = 4'd0;
	localparam logic [CMD_W-1:0] CMD_SET_STATE  = 4'd1;
	localparam logic [CMD_W-1:0] CMD_SET_INPUT  = 4'd2;
	localparam logic [CMD_W-1:0] CMD_SET_OUTPUT = 4'd3;
	localparam logic [CMD_W-1:0] CMD_TOGGLE     = 4'd4;
	localparam logic [CMD_W-1:0] CMD_GET_MODE   = 4'd5;
	localparam logic [CMD_W-1:0] CMD_GET_STATE  = 4'd6;
	localparam logic [CMD_W-1:0] CMD_GET_INPUT  = 4'd7;
	localparam logic [CMD_W-1:0] CMD_GET_OUTPUT = 4'd8;

	localparam logic [MODE_W-1:0] MODE_INIT   = 4'd0;
	localparam logic [MODE_W-1:0] MODE_PP     = 4'd1;
	localparam logic [MODE_W-1:0] MODE_PP_ALT = 4'd2;
	localparam logic [MODE_W-1:0] MODE_OD     = 4'd3;
	localparam logic [MODE_W-1:0] MODE_OD_ALT = 4'd4;
	localparam logic [MODE_W-1:0] MODE_IN     = 4'd5;
	localparam logic [MODE_W-1:0] MODE_IN_AF  = 4'd6;
	localparam logic [MODE_W-1:0] MODE_ANALOG = 4'd7;

	localparam logic [LEVEL_W-1:0] LVL_LOW   = 2'd0;
	localparam logic [LEVEL_W-1:0] LVL_HIGH  = 2'd1;
	localparam logic [LEVEL_W-1:0] LVL_FLOAT = 2'd2;

	localparam logic [NIB_W-1:0] CNF_AF     = 4'b1000;
	localparam logic [NIB_W-1:0] CNF_OD     = 4'b0100;
	localparam logic [NIB_W-1:0] SPEED_SLOW = 4'b0010;
	localparam logic [NIB_W-1:0] NIB_INP    = 4'b1000;
	localparam logic [NIB_W-1:0] NIB_INF    = 4'b0100;
	localparam logic [NIB_W-1:0] NIB_AN     = 4'b0000;

	localparam logic [PIN_W-1:0] PSW_FIRST_PIN = 4'd13;

	localparam logic [CFG_IDX_W-1:0] REG_SPEED      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLOAT_TGL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_CHK   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PSW_ENABLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PSW_PORT   = 3'd4;

endpackage

// File: rtl/gpio_pin_mode_controller_core.sv
// GPIO port block: per-pin configuration nibble and output latch held in one memory.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------------
//  in       | in_valid / in_ready    | command, port_index, pin_number, mode_request,
//           |                        | level_request, pin_input_level
//  out      | out_valid / out_ready  | status, mode_read, level_read, config_nibble,
//           |                        | latch_bit
//  cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Each beat reads the pin's entry from the state memory, then modifies it, writes it back
// and loads the result register. A new beat is taken while a result still waits on the
// output, not while the last beat is in the modify stage. The single read port and the
// write back of the same entry set this limit. Reset clears per-entry valid bits, so no
// clearing pass is needed. Output stalls hold the modify stage once the result is full.
module gpio_pin_mode_controller_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gpm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gpm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [gpm_pkg::CMD_W-1:0]           command,
	input  logic [gpm_pkg::PORT_W-1:0]          port_index,
	input  logic [gpm_pkg::PIN_W-1:0]           pin_number,
	input  logic [gpm_pkg::MODE_W-1:0]          mode_request,
	input  logic [gpm_pkg::LEVEL_W-1:0]         level_request,
	input  logic                                pin_input_level,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                status,
	output logic [gpm_pkg::MODE_W-1:0]          mode_read,
	output logic [gpm_pkg::LEVEL_W-1:0]         level_read,
	output logic [gpm_pkg::NIB_W-1:0]           config_nibble,
	output logic                                latch_bit
);
	import gpm_pkg::*;

	logic [1:0] speed_q;
	logic       float_tgl_q;
	logic       init_chk_q;
	logic       psw_en_q;
	logic [1:0] psw_port_q;

	logic [NIB_W:0]  mem [DEPTH];
	logic [DEPTH-1:0] vld_q;

	logic                 v_s1;
	logic [ADDR_W-1:0]    addr_s1;
	logic [NIB_W:0]       rd_s1;
	logic [CMD_W-1:0]     cmd_s1;
	logic [PORT_W-1:0]    port_s1;
	logic [PIN_W-1:0]     pin_s1;
	logic [MODE_W-1:0]    mreq_s1;
	logic [LEVEL_W-1:0]   lvl_s1;
	logic                 inlvl_s1;

	logic                 out_valid_q;
	logic                 status_q;
	logic [MODE_W-1:0]    mode_q;
	logic [LEVEL_W-1:0]   level_q;
	logic [NIB_W-1:0]     nib_q;
	logic                 latch_q;

	logic                 in_fire;
	logic                 s1_fire;
	logic                 port_ok;
	logic [NIB_W-1:0]     nib;
	logic                 lat;
	logic [NIB_W-1:0]     new_nib;
	logic                 new_lat;
	logic                 new_status;
	logic [MODE_W-1:0]    new_mode;
	logic [LEVEL_W-1:0]   new_level;
	logic                 is_out;
	logic                 is_dig;
	logic                 psw;
	logic [NIB_W-1:0]     sp;
	logic                 od;

	assign cfg_ready = 1'b1;
	assign in_ready  = !v_s1;
	assign in_fire   = in_valid && in_ready;
	assign s1_fire   = v_s1 && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q     <= 2'd2;
			float_tgl_q <= 1'b0;
			init_chk_q  <= 1'b1;
			psw_en_q    <= 1'b1;
			psw_port_q  <= 2'd2;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SPEED:      speed_q     <= cfg_data[1:0];
				REG_FLOAT_TGL:  float_tgl_q <= cfg_data[0];
				REG_INIT_CHK:   init_chk_q  <= cfg_data[0];
				REG_PSW_ENABLE: psw_en_q    <= cfg_data[0];
				REG_PSW_PORT:   psw_port_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			rd_s1    <= mem[ADDR_W'({port_index, pin_number})];
			addr_s1  <= ADDR_W'({port_index, pin_number});
			cmd_s1   <= command;
			port_s1  <= port_index;
			pin_s1   <= pin_number;
			mreq_s1  <= mode_request;
			lvl_s1   <= level_request;
			inlvl_s1 <= pin_input_level;
		end
		if (s1_fire && port_ok) begin
			mem[addr_s1] <= {new_lat, new_nib};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				v_s1 <= 1'b1;
			end else if (s1_fire) begin
				v_s1 <= 1'b0;
			end
			if (s1_fire && port_ok) begin
				vld_q[addr_s1] <= 1'b1;
			end
			if (s1_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		port_ok = (int'(port_s1) < NUM_PORTS);
		nib     = vld_q[addr_s1] ? rd_s1[NIB_W-1:0] : NIB_AN;
		lat     = vld_q[addr_s1] ? rd_s1[NIB_W] : 1'b0;
		is_out  = (nib[1:0] != 2'b00);
		is_dig  = (nib == NIB_INP) || (nib == NIB_INF);
		od      = is_out && nib[2];
		psw     = psw_en_q && (port_s1 == psw_port_q) && (pin_s1 >= PSW_FIRST_PIN);
		sp      = (speed_q == 2'd0) ? SPEED_SLOW : {2'b00, speed_q};

		new_nib    = nib;
		new_lat    = lat;
		new_status = 1'b0;
		new_mode   = MODE_INIT;
		new_level  = LVL_LOW;

		case (cmd_s1)
			CMD_SET_MODE: begin
				case (mreq_s1)
					MODE_PP:     new_nib = psw ? (CNF_OD | SPEED_SLOW) : sp;
					MODE_PP_ALT: new_nib = psw ? (CNF_AF | CNF_OD | SPEED_SLOW) : (CNF_AF | sp);
					MODE_OD:     new_nib = psw ? (CNF_OD | SPEED_SLOW) : (CNF_OD | sp);
					MODE_OD_ALT: new_nib = psw ? (CNF_AF | CNF_OD | SPEED_SLOW)
						: (CNF_AF | CNF_OD | sp);
					MODE_IN, MODE_IN_AF: new_nib = (lvl_s1 <= LVL_HIGH) ? NIB_INP : NIB_INF;
					default: new_nib = NIB_AN;
				endcase
				if (mreq_s1 inside {MODE_PP_ALT, MODE_OD_ALT}) begin
					new_lat = lat;
				end else if (mreq_s1 inside {MODE_PP, MODE_OD, MODE_IN, MODE_IN_AF}) begin
					if (lvl_s1 == LVL_LOW) begin
						new_lat = 1'b0;
					end else if (lvl_s1 == LVL_HIGH) begin
						new_lat = 1'b1;
					end
				end else begin
					new_lat = 1'b0;
				end
			end
			CMD_SET_STATE, CMD_SET_INPUT, CMD_SET_OUTPUT: begin
				if ((cmd_s1 == CMD_SET_INPUT && init_chk_q && !is_dig)
						|| (cmd_s1 == CMD_SET_OUTPUT && init_chk_q && !is_out)) begin
					new_status = 1'b1;
				end else if ((cmd_s1 == CMD_SET_OUTPUT)
						|| (cmd_s1 == CMD_SET_STATE && is_out)) begin
					if (lvl_s1 == LVL_LOW) begin
						new_lat = 1'b0;
					end else if (lvl_s1 == LVL_HIGH) begin
						new_lat = 1'b1;
					end else if (float_tgl_q) begin
						new_lat = !lat;
					end
				end else if ((cmd_s1 == CMD_SET_INPUT) || is_dig) begin
					if (lvl_s1 == LVL_LOW) begin
						new_lat = 1'b0;
						new_nib = NIB_INP;
					end else if (lvl_s1 == LVL_HIGH) begin
						new_lat = 1'b1;
						new_nib = NIB_INP;
					end else begin
						new_nib = NIB_INF;
					end
				end
			end
			CMD_TOGGLE: new_lat = !lat;
			CMD_GET_MODE: begin
				if (is_out) begin
					case (nib[3:2])
						2'b00:   new_mode = MODE_PP;
						2'b01:   new_mode = MODE_OD;
						2'b10:   new_mode = MODE_PP_ALT;
						default: new_mode = MODE_OD_ALT;
					endcase
				end else if (nib[3:2] == 2'b00) begin
					new_mode = MODE_ANALOG;
				end else if (nib[3:2] == 2'b11) begin
					new_mode = MODE_INIT;
				end else begin
					new_mode = MODE_IN;
				end
			end
			CMD_GET_STATE: begin
				if (is_out) begin
					new_level = {1'b0, lat};
				end else if (is_dig) begin
					new_level = {1'b0, inlvl_s1};
				end else begin
					new_level = LVL_FLOAT;
				end
			end
			CMD_GET_INPUT: begin
				if (init_chk_q && !is_dig && !od) begin
					new_level = LVL_FLOAT;
				end else begin
					new_level = {1'b0, inlvl_s1};
				end
			end
			CMD_GET_OUTPUT: begin
				if (init_chk_q && !is_out) begin
					new_level = LVL_FLOAT;
				end else begin
					new_level = {1'b0, lat};
				end
			end
			default: ;
		endcase

		if (!port_ok) begin
			new_nib    = NIB_AN;
			new_lat    = 1'b0;
			new_status = 1'b0;
			new_mode   = MODE_INIT;
			new_level  = (cmd_s1 inside {[CMD_GET_STATE:CMD_GET_OUTPUT]}) ? LVL_FLOAT : LVL_LOW;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			status_q <= new_status;
			mode_q   <= new_mode;
			level_q  <= new_level;
			nib_q    <= new_nib;
			latch_q  <= new_lat;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign mode_read     = mode_q;
	assign level_read    = level_q;
	assign config_nibble = nib_q;
	assign latch_bit     = latch_q;

endmodule
